[rtl/rpa_pkg.sv]
package rpa_pkg;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_FULL     = 3'd1,
		ST_CLEARED  = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_BELOW    = 3'd4,
		ST_NEW      = 3'd5,
		ST_REPLACED = 3'd6,
		ST_KEPT     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_TOL   = 2'd0,
		CFG_FLOOR = 2'd1,
		CFG_FUNC  = 2'd2,
		CFG_SPARE = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LO_RD,
		S_LO_CMP,
		S_HI_RD,
		S_HI_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_BEST_RD,
		S_BEST_CHK,
		S_ASN_RD,
		S_ASN_CHK,
		S_CLEAR,
		S_OUT
	} state_t;

	localparam logic [31:0] TOL_RESET = 32'd6554;

endpackage

[rtl/rpa_peak_mem.sv]
module rpa_peak_mem
	import rpa_pkg::*;
#(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wmass,
	input  logic [31:0]   winten,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rmass,
	output logic [31:0]   rinten
);
	logic [31:0] mass_mem [2**AW];
	logic [31:0] inten_mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mass_mem[waddr] <= wmass;
			inten_mem[waddr] <= winten;
		end
		rmass <= mass_mem[raddr];
		rinten <= inten_mem[raddr];
	end
endmodule

[rtl/rpa_assign_mem.sv]
module rpa_assign_mem
	import rpa_pkg::*;
#(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [56:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [56:0]   rdata
);
	logic [56:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/reference_peak_assigner_core.sv]
// Tolerance-window peak assigner.
// Input channel (valid/stall): op, mass_value, peak_intensity, reference_id.
//   op 0 loads a peak at the next slot, op 1 queries a reference mass,
//   op 2 clears peaks and assignments, op 3 is dropped with no result.
// Output channel (valid/stall): one result per op 0..2, held in an output
//   register until taken; the core accepts no new transaction meanwhile.
// Config channel (valid/ready): cfg_index 0 tolerance, 1 floor, 2 function.
// Load and clear results are registered at accept. A query runs two
//   window searches (halving steps, up to 11 at 1024 peaks), a scan of
//   the window peaks for the highest intensity, then the assignment
//   check; an empty window ends after the searches, a peak below the
//   floor after the scan. The scan through the single peak memory port
//   sets the query time.
// Throughput: one transaction at a time; the next is taken once the result
//   has been taken. After op 2 and after reset the assignment memory is
//   swept one entry per cycle over all 2**clog2(PEAK_DEPTH) entries, input stalled.
// Reset clears the peak count, resets the configuration and starts the sweep.
// A stalled output holds its result; the core waits until it is taken.
module reference_peak_assigner_core
	import rpa_pkg::*;
#(
	parameter int PEAK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] mass_value,
	input  logic [31:0] peak_intensity,
	input  logic [15:0] reference_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  peak_index,
	output logic [31:0] peak_mass,
	output logic [15:0] echoed_reference,
	output logic [15:0] displaced_reference,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = $clog2(PEAK_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(PEAK_DEPTH);
	localparam logic [AW:0] LAST_C = (AW+1)'(2**AW - 1);

	state_t state_q, state_d;
	logic [31:0] tol_q, floor_q;
	logic [7:0] func_q;
	logic [CW-1:0] count_q;
	logic [33:0] key_q;
	logic [31:0] mass_q;
	logic [15:0] ref_q;
	logic [CW-1:0] first_q, len_q, lo_q, hi_q, i_q, best_q;
	logic [31:0] best_int_q, pm_q;
	logic [AW:0] vclr_q;

	logic pm_we;
	logic [AW-1:0] pm_raddr;
	logic [31:0] rmass, rinten;
	logic am_we;
	logic [AW-1:0] am_waddr, am_raddr;
	logic [56:0] am_wdata, am_rdata;
	logic [CW-1:0] half, mid;
	logic [31:0] err;
	logic accept;

	// assignment entry: valid | func | ref | err; valid cleared by sweep
	assign half = len_q >> 1;
	assign mid = first_q + half;
	assign err = (mass_q >= pm_q) ? mass_q - pm_q : pm_q - mass_q;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	rpa_peak_mem #(.AW(AW)) u_pm (
		.clk(clk), .we(pm_we), .waddr(count_q[AW-1:0]), .wmass(mass_value),
		.winten(peak_intensity), .raddr(pm_raddr), .rmass(rmass), .rinten(rinten)
	);

	rpa_assign_mem #(.AW(AW)) u_am (
		.clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
		.raddr(am_raddr), .rdata(am_rdata)
	);

	assign pm_we = accept && op == OP_LOAD && count_q != DEPTH_C;

	always_comb begin
		state_d = state_q;
		pm_raddr = mid[AW-1:0];
		am_raddr = best_q[AW-1:0];
		am_we = 1'b0;
		am_waddr = best_q[AW-1:0];
		am_wdata = {1'b1, func_q, ref_q, err};
		unique case (state_q)
			S_IDLE:     if (accept && op == OP_QUERY) state_d = S_LO_RD;
			S_LO_RD:    if (len_q == '0) state_d = S_HI_RD;
				else state_d = S_LO_CMP;
			S_LO_CMP:   state_d = S_LO_RD;
			S_HI_RD:    if (len_q == '0) state_d = S_SCAN_RD;
				else state_d = S_HI_CMP;
			S_HI_CMP:   state_d = S_HI_RD;
			S_SCAN_RD: begin
				pm_raddr = i_q[AW-1:0];
				if (lo_q >= hi_q) state_d = S_OUT;
				else if (i_q >= hi_q) state_d = S_BEST_RD;
				else state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: state_d = S_SCAN_RD;
			S_BEST_RD: begin
				pm_raddr = best_q[AW-1:0];
				state_d = S_BEST_CHK;
			end
			S_BEST_CHK: if (best_int_q < floor_q) state_d = S_OUT;
				else state_d = S_ASN_RD;
			S_ASN_RD:   state_d = S_ASN_CHK;
			S_ASN_CHK: begin
				if (am_rdata[56] && am_rdata[55:48] == func_q) begin
					if (am_rdata[31:0] > err) begin
						am_we = 1'b1;
						am_wdata = {am_rdata[56:48], ref_q, err};
					end
				end else begin
					am_we = 1'b1;
				end
				state_d = S_OUT;
			end
			S_CLEAR: begin
				am_we = 1'b1;
				am_waddr = vclr_q[AW-1:0];
				am_wdata = '0;
				if (vclr_q == LAST_C) state_d = S_IDLE;
			end
			S_OUT:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
		if (state_q == S_IDLE && accept && op == OP_CLEAR) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tol_q <= TOL_RESET;
			floor_q <= '0;
			func_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
			vclr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_TOL:   tol_q <= cfg_data;
					CFG_FLOOR: floor_q <= cfg_data;
					CFG_FUNC:  func_q <= cfg_data[7:0];
					CFG_SPARE: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == S_CLEAR) vclr_q <= vclr_q + 1'b1;
			else vclr_q <= '0;
			if (accept) begin
				unique case (op_t'(op))
					OP_LOAD: begin
						out_valid <= 1'b1;
						if (count_q != DEPTH_C) count_q <= count_q + 1'b1;
					end
					OP_CLEAR: begin
						out_valid <= 1'b1;
						count_q <= '0;
					end
					OP_QUERY, OP_NONE: ;
				endcase
			end
			if (state_q == S_OUT) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mass_q <= mass_value;
			ref_q <= reference_id;
			first_q <= '0;
			len_q <= count_q;
			key_q <= {2'b00, mass_value} - {2'b00, tol_q};
			displaced_reference <= '0;
			echoed_reference <= '0;
			unique case (op_t'(op))
				OP_LOAD: begin
					if (count_q != DEPTH_C) begin
						status <= ST_STORED;
						peak_index <= 10'(count_q);
						peak_mass <= mass_value;
					end else begin
						status <= ST_FULL;
						peak_index <= '0;
						peak_mass <= '0;
					end
				end
				OP_CLEAR: begin
					status <= ST_CLEARED;
					peak_index <= '0;
					peak_mass <= '0;
				end
				OP_QUERY, OP_NONE: begin
					status <= ST_EMPTY;
					peak_index <= '0;
					peak_mass <= '0;
				end
			endcase
		end
		unique case (state_q)
			S_LO_RD: if (len_q == '0) begin
				lo_q <= first_q;
				first_q <= '0;
				len_q <= count_q;
				key_q <= {2'b00, mass_q} + {2'b00, tol_q};
			end
			S_LO_CMP, S_HI_CMP: begin
				if ($signed({2'b00, rmass}) < $signed(key_q)) begin
					first_q <= mid + 1'b1;
					len_q <= len_q - half - 1'b1;
				end else begin
					len_q <= half;
				end
			end
			S_HI_RD: if (len_q == '0) begin
				hi_q <= first_q;
				i_q <= lo_q;
				best_q <= lo_q;
				best_int_q <= '0;
			end
			S_SCAN_RD: begin
				if (lo_q >= hi_q) begin
					status <= ST_EMPTY;
					echoed_reference <= ref_q;
				end
			end
			S_SCAN_CMP: begin
				if (i_q == lo_q || rinten > best_int_q) begin
					best_q <= i_q;
					best_int_q <= rinten;
				end
				i_q <= i_q + 1'b1;
			end
			S_BEST_CHK: begin
				pm_q <= rmass;
				peak_index <= 10'(best_q);
				peak_mass <= rmass;
				echoed_reference <= ref_q;
				status <= ST_BELOW;
			end
			S_ASN_CHK: begin
				if (am_rdata[56] && am_rdata[55:48] == func_q) begin
					displaced_reference <= am_rdata[47:32];
					status <= (am_rdata[31:0] > err) ? ST_REPLACED : ST_KEPT;
				end else begin
					status <= ST_NEW;
				end
			end
			default: ;
		endcase
	end
endmodule

[verif/tb.sv]
module tb;
	import rpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam int NUM_ITEMS = 1850;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  index;
		logic [31:0] mass;
		logic [15:0] echo;
		logic [15:0] displaced;
	} result_t;

	class assign_scoreboard;
		logic [31:0] tol;
		logic [31:0] floor_lvl;
		logic [7:0]  func;
		logic [31:0] pk_mass [DEPTH];
		logic [31:0] pk_int [DEPTH];
		int unsigned count;
		bit          a_valid [DEPTH];
		logic [15:0] a_ref [DEPTH];
		logic [31:0] a_err [DEPTH];
		logic [7:0]  a_func [DEPTH];
		result_t     pending[$];
		int          errors;
		int          checked;
		int          status_seen [8];

		function void init();
			tol = TOL_RESET;
			floor_lvl = 0;
			func = 0;
			count = 0;
			errors = 0;
			checked = 0;
			foreach (a_valid[i]) a_valid[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] data);
			case (idx)
				CFG_TOL: tol = data;
				CFG_FLOOR: floor_lvl = data;
				CFG_FUNC: func = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned find_first(longint key);
			int unsigned first, len, half, mid;
			first = 0;
			len = count;
			while (len > 0) begin
				half = len / 2;
				mid = first + half;
				if (longint'(pk_mass[mid]) < key) begin
					first = mid + 1;
					len -= half + 1;
				end else begin
					len = half;
				end
			end
			return first;
		endfunction

		function void note_input(op_t o, logic [31:0] m, logic [31:0] inten, logic [15:0] id);
			result_t r;
			int unsigned lo, hi, best;
			logic [31:0] err, pm;
			r = '0;
			case (o)
				OP_LOAD: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						pk_mass[count] = m;
						pk_int[count] = inten;
						r.status = ST_STORED;
						r.index = count[9:0];
						r.mass = m;
						count++;
					end
				end
				OP_CLEAR: begin
					count = 0;
					foreach (a_valid[i]) a_valid[i] = 0;
					r.status = ST_CLEARED;
				end
				OP_QUERY: begin
					r.echo = id;
					lo = find_first(longint'(m) - longint'(tol));
					hi = find_first(longint'(m) + longint'(tol));
					if (lo >= hi) begin
						r.status = ST_EMPTY;
					end else begin
						best = lo;
						for (int unsigned i = lo + 1; i < hi; i++)
							if (pk_int[i] > pk_int[best]) best = i;
						pm = pk_mass[best];
						r.index = best[9:0];
						r.mass = pm;
						err = (m >= pm) ? m - pm : pm - m;
						if (pk_int[best] < floor_lvl) begin
							r.status = ST_BELOW;
						end else if (a_valid[best] && a_func[best] == func) begin
							r.displaced = a_ref[best];
							if (a_err[best] > err) begin
								a_ref[best] = id;
								a_err[best] = err;
								r.status = ST_REPLACED;
							end else begin
								r.status = ST_KEPT;
							end
						end else begin
							a_valid[best] = 1;
							a_ref[best] = id;
							a_err[best] = err;
							a_func[best] = func;
							r.status = ST_NEW;
						end
					end
				end
				default: return;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			checked++;
			status_seen[got.status]++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected st=%0d idx=%0d m=%h ref=%0d disp=%0d,",
						" got st=%0d idx=%0d m=%h ref=%0d disp=%0d"},
						exp.status, exp.index, exp.mass, exp.echo, exp.displaced,
						got.status, got.index, got.mass, got.echo, got.displaced);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [31:0] mass_value;
	logic [31:0] peak_intensity;
	logic [15:0] reference_id;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [9:0]  peak_index;
	logic [31:0] peak_mass;
	logic [15:0] echoed_reference;
	logic [15:0] displaced_reference;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	reference_peak_assigner_core u_top (.*);

	assign_scoreboard sb;
	int  idle_cycles;
	bit  quiet;
	bit  hold_off;
	bit  timed_out;
	int  sent;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired");
			$display("tb failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result({status, peak_index, peak_mass, echoed_reference,
				displaced_reference});

	// result-side stall: random bursts, long hold-off on request
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (3000) @(negedge clk);
				out_stall <= 0;
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic send(op_t o, logic [31:0] m, logic [31:0] inten, logic [15:0] id);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		op <= o;
		mass_value <= m;
		peak_intensity <= inten;
		reference_id <= id;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(o, m, inten, id);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic load_sorted(int n, logic [31:0] start, int max_step);
		logic [31:0] m;
		m = start;
		for (int i = 0; i < n; i++) begin
			send(OP_LOAD, m, $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom(),
				16'($urandom()));
			m = m + $urandom_range(0, max_step);
		end
	endtask

	task automatic random_query(logic [31:0] base, int span);
		send(OP_QUERY, base + $urandom_range(0, span), $urandom(), 16'($urandom()));
	endtask

	initial begin
		sb = new();
		sb.init();
		arst_n = 0;
		in_valid = 0;
		op = OP_NONE;
		mass_value = 0;
		peak_intensity = 0;
		reference_id = 0;
		cfg_valid = 0;
		cfg_index = CFG_TOL;
		cfg_data = 0;
		quiet = 0;
		hold_off = 0;
		timed_out = 0;
		idle_cycles = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		send(OP_QUERY, 32'h0001_0000, 0, 16'hFFFF);
		send(OP_LOAD, 32'h0, 32'hFFFF_FFFF, 16'h0);
		send(OP_LOAD, 32'h0000_8000, 32'h0, 16'h0);
		send(OP_LOAD, 32'h0001_0000, 32'h10, 16'h0);
		send(OP_LOAD, 32'h0001_0000, 32'h10, 16'h0);
		send(OP_LOAD, 32'hFFFF_FFFF, 32'h5, 16'h0);
		send(OP_NONE, 32'h1234, 32'h5678, 16'h9);
		send(OP_QUERY, 32'h0, 0, 16'h1);
		send(OP_QUERY, 32'h0, 0, 16'h2);
		send(OP_QUERY, 32'h0001_0000, 0, 16'h3);
		send(OP_QUERY, 32'h0001_0100, 0, 16'h4);
		send(OP_QUERY, 32'h0000_FF00, 0, 16'h5);
		send(OP_QUERY, 32'hFFFF_FFFF, 0, 16'hFFFF);
		send(OP_QUERY, 32'h8000_0000, 0, 16'h6);
		drain();
		write_reg(CFG_FLOOR, 32'h11);
		write_reg(CFG_FUNC, 32'hFF);
		write_reg(CFG_TOL, 32'hFFFF_FFFF);
		send(OP_QUERY, 32'h0001_0000, 0, 16'h7);
		send(OP_QUERY, 32'h7FFF_0000, 0, 16'h8);
		drain();
		write_reg(CFG_FLOOR, 0);
		send(OP_QUERY, 32'h0001_0000, 0, 16'h9);
		send(OP_QUERY, 32'hFFFF_FFFF, 0, 16'hA);
		drain();
		write_reg(CFG_TOL, 0);
		send(OP_QUERY, 32'h0001_0000, 0, 16'hB);
		send(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		drain();

		// store full, with a long receiver hold-off while loads keep coming
		write_reg(CFG_TOL, 32'h0000_4000);
		hold_off = 1;
		load_sorted(DEPTH + 3, 32'h1000_0000, 32'h2000);
		for (int i = 0; i < 20; i++) random_query(32'h1000_0000, 32'h0100_0000);
		send(OP_CLEAR, 0, 0, 0);
		drain();

		// random phases with assorted settings
		while (sent < NUM_ITEMS) begin
			int n;
			logic [31:0] base;
			if (sent > NUM_ITEMS - 300) quiet = 1;
			case ($urandom_range(0, 3))
				0: write_reg(CFG_TOL, $urandom_range(0, 32'h0004_0000));
				1: write_reg(CFG_TOL, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
				default: write_reg(CFG_TOL, $urandom_range(0, 32'h0000_2000));
			endcase
			write_reg(CFG_FLOOR, $urandom_range(0, 1) ? 0 :
				($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom()));
			write_reg(CFG_FUNC, $urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0) send(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
			n = $urandom_range(1, 24);
			base = $urandom_range(0, 7) == 0 ? 32'hFFF0_0000 : $urandom_range(0, 32'h8000_0000);
			if ($urandom_range(0, 4) == 0) begin
				for (int i = 0; i < n; i++)
					send(OP_LOAD, $urandom(), $urandom(), 16'($urandom()));
			end else begin
				load_sorted(n, base, 32'h1000);
			end
			if (!hold_off && !quiet && $urandom_range(0, 15) == 0) hold_off = 1;
			for (int i = 0; i < 3 * n; i++) begin
				case ($urandom_range(0, 15))
					0: send(OP_NONE, $urandom(), $urandom(), 16'($urandom()));
					1: send(OP_QUERY, $urandom(), $urandom(), 16'($urandom()));
					2: send(OP_LOAD, base + 32'h0010_0000, $urandom(), 0);
					default: send(OP_QUERY, base + $urandom_range(0, n * 32'h1000),
						$urandom(), 16'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom()));
				endcase
			end
			drain();
		end

		drain();
		$display("covered loads up to a full store, clears, window queries and %0d transactions",
			sent);
		$display("results: stored %0d full %0d cleared %0d empty %0d below %0d new %0d rep %0d kept %0d",
			sb.status_seen[ST_STORED], sb.status_seen[ST_FULL], sb.status_seen[ST_CLEARED],
			sb.status_seen[ST_EMPTY], sb.status_seen[ST_BELOW], sb.status_seen[ST_NEW],
			sb.status_seen[ST_REPLACED], sb.status_seen[ST_KEPT]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
			$display("tb failed");
		end
		$finish;
	end
endmodule
